### hw/rtl/amfp_pkg.sv
// amfp_pkg: shared types, constants and helper functions for the affine matrix block
// no dependencies; imported by every module of the block
package amfp_pkg;

   // fixed-point formats
   localparam int FRAC_BITS    = 16;
   localparam int TRIG_FRAC    = 30;
   localparam int ATAN_ENTRIES = 24;
   localparam int WRAP_W       = 25;

   // cordic start value (Q2.30 gain)
   localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

   // angle reduction constants, modulus is 45 * 2^19
   localparam logic [10:0] HRECIP    = 11'd1457;        // about 2^16 / 45
   localparam logic [5:0]  DIV45     = 6'd45;
   localparam logic [5:0]  HM_TOP    = 6'd44;
   localparam logic [4:0]  TURN_REM  = 5'd31;           // 2^32 mod 45
   localparam logic [26:0] TURN_STEP = 27'd95443717;    // floor(2^32 / 45)
   localparam logic [32:0] DRECIP    = 33'd6108397932;  // floor(2^38 / 45)

   // input word
   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [31:0] angle_deg;
   } req_type;

   // result word
   typedef struct packed {
      logic signed [31:0] xx_term;
      logic signed [31:0] xy_term;
      logic signed [31:0] yx_term;
      logic signed [31:0] yy_term;
      logic signed [31:0] shift_x;
      logic signed [31:0] shift_y;
      logic [WRAP_W-1:0]  angle_wrapped;
   } rsp_type;

   // pose data riding along the pipeline
   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic [WRAP_W-1:0]  angle_wrapped;
      logic [1:0]         quad;
   } carry_type;

   // rotation vector and residual binary angle
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } cordic_type;

   // arctangent of 2^-idx in binary angle units (2^32 per turn)
   function automatic logic signed [31:0] atan_turn(input int idx);
      logic signed [31:0] v;
      case (idx)
         0:  v = 32'sd536870912;
         1:  v = 32'sd316933406;
         2:  v = 32'sd167458907;
         3:  v = 32'sd85004756;
         4:  v = 32'sd42667331;
         5:  v = 32'sd21354465;
         6:  v = 32'sd10680350;
         7:  v = 32'sd5340245;
         8:  v = 32'sd2670163;
         9:  v = 32'sd1335087;
         10: v = 32'sd667544;
         11: v = 32'sd333772;
         12: v = 32'sd166886;
         13: v = 32'sd83443;
         14: v = 32'sd41721;
         15: v = 32'sd20860;
         16: v = 32'sd10430;
         17: v = 32'sd5215;
         18: v = 32'sd2607;
         19: v = 32'sd1303;
         20: v = 32'sd651;
         21: v = 32'sd325;
         22: v = 32'sd162;
         23: v = 32'sd81;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

   // clamp a wide signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
      logic signed [31:0] r;
      if (v > 56'sd2147483647)
         r = 32'sh7fffffff;
      else if (v < -56'sd2147483648)
         r = 32'sh80000000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage

### hw/rtl/amfp_wrap.sv
// amfp_wrap: six-stage angle reduction modulo 360 degrees and binary angle conversion
// depends on amfp_pkg
module amfp_wrap (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  amfp_pkg::req_type     in_word,
   output logic                  out_valid,
   output amfp_pkg::carry_type   out_carry,
   output amfp_pkg::cordic_type  out_vec
);
   import amfp_pkg::*;

   // stage registers
   logic [5:0]          valid_ff;
   logic [5:0]          valid_in;
   carry_type           c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;
   logic [12:0]         h1_ff;
   logic [7:0]          q1_ff;
   logic [18:0]         l1_ff;
   logic [5:0]          hm2_ff;
   logic [18:0]         l2_ff;
   logic [32:0]         d3_ff, d4_ff;
   logic [31:0]         base3_ff, base4_ff, base5_ff;
   logic [65:0]         pd4_ff;
   logic [27:0]         est5_ff;
   logic signed [34:0]  rem5_ff;
   logic [31:0]         turn6_ff;

   // stage 1: split into 45-free part and estimate quotient of high part
   logic [12:0] h1_in;
   logic [23:0] hp1;
   carry_type   c1_in;
   assign h1_in = {~in_word.angle_deg[31], in_word.angle_deg[30:19]};
   assign hp1   = 24'(h1_in) * 24'(HRECIP);
   always_comb begin
      c1_in               = '0;
      c1_in.origin_x      = in_word.origin_x;
      c1_in.origin_y      = in_word.origin_y;
      c1_in.pos_x         = in_word.pos_x;
      c1_in.pos_y         = in_word.pos_y;
      c1_in.scale_x       = in_word.scale_x;
      c1_in.scale_y       = in_word.scale_y;
   end

   // stage 2: remainder of high part mod 45, offset back for the sign bias
   logic signed [14:0] r2a;
   logic signed [14:0] r2b;
   logic [5:0]         hm2_in;
   carry_type          c2_in;
   always_comb begin
      r2a = $signed({2'b00, h1_ff}) - $signed(15'(14'(q1_ff) * 14'(DIV45)));
      if (r2a < 15'sd0)
         r2b = r2a + 15'sd45;
      else if (r2a >= 15'sd45)
         r2b = r2a - 15'sd45;
      else
         r2b = r2a;
      if (r2b == 15'sd0)
         hm2_in = HM_TOP;
      else
         hm2_in = 6'(r2b - 15'sd1);
      c2_in               = c1_ff;
      c2_in.angle_wrapped = {hm2_in[5:0], l1_ff};
   end

   // stage 3: split turn = hm*floor(2^32/45) + floor(d/45)
   logic [32:0] d3_in;
   logic [31:0] base3_in;
   assign d3_in    = 33'(hm2_ff) * 33'(TURN_REM) + {1'b0, l2_ff, 13'b0};
   assign base3_in = 32'(32'(hm2_ff) * 32'(TURN_STEP));

   // stage 4: reciprocal product
   logic [65:0] pd4_in;
   assign pd4_in = 66'(d3_ff) * 66'(DRECIP);

   // stage 5: quotient estimate and remainder
   logic [27:0]        est5_in;
   logic signed [34:0] rem5_in;
   assign est5_in = pd4_ff[65:38];
   assign rem5_in = $signed({2'b00, d4_ff}) - $signed(35'(35'(est5_in) * 35'(DIV45)));

   // stage 6: correct estimate and add base
   logic [31:0] turn6_in;
   carry_type   c6_in;
   always_comb begin
      turn6_in = base5_ff + 32'(est5_ff) + ((rem5_ff >= 35'sd45) ? 32'd1 : 32'd0);
      c6_in      = c5_ff;
      c6_in.quad = turn6_in[31:30];
   end

   assign valid_in = {valid_ff[4:0], in_valid};

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= '0;
      else
         valid_ff <= valid_in;
      c1_ff    <= c1_in;
      h1_ff    <= h1_in;
      q1_ff    <= hp1[23:16];
      l1_ff    <= in_word.angle_deg[18:0];
      c2_ff    <= c2_in;
      hm2_ff   <= hm2_in;
      l2_ff    <= l1_ff;
      c3_ff    <= c2_ff;
      d3_ff    <= d3_in;
      base3_ff <= base3_in;
      c4_ff    <= c3_ff;
      d4_ff    <= d3_ff;
      base4_ff <= base3_ff;
      pd4_ff   <= pd4_in;
      c5_ff    <= c4_ff;
      est5_ff  <= est5_in;
      rem5_ff  <= rem5_in;
      base5_ff <= base4_ff;
      c6_ff    <= c6_in;
      turn6_ff <= turn6_in;
   end

   // cordic start vector
   assign out_valid = valid_ff[5];
   assign out_carry = c6_ff;
   assign out_vec.x = CORDIC_GAIN;
   assign out_vec.y = 32'sd0;
   assign out_vec.z = $signed({2'b00, turn6_ff[29:0]});

endmodule

### hw/rtl/amfp_cell.sv
// amfp_cell: one cordic rotation step with its own shift and arctangent constant
// depends on amfp_pkg
module amfp_cell #(
   parameter int STEP = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  amfp_pkg::cordic_type  in_vec,
   input  amfp_pkg::carry_type   in_carry,
   output logic                  out_valid,
   output amfp_pkg::cordic_type  out_vec,
   output amfp_pkg::carry_type   out_carry
);
   import amfp_pkg::*;

   localparam logic signed [31:0] ATAN = atan_turn(STEP);

   logic               valid_ff;
   cordic_type         vec_ff, vec_in;
   carry_type          carry_ff;
   logic signed [31:0] dx, dy;

   // rotate toward zero residual angle
   assign dx = $signed(in_vec.y) >>> STEP;
   assign dy = $signed(in_vec.x) >>> STEP;
   always_comb begin
      if (!in_vec.z[31]) begin
         vec_in.x = in_vec.x - dx;
         vec_in.y = in_vec.y + dy;
         vec_in.z = in_vec.z - ATAN;
      end else begin
         vec_in.x = in_vec.x + dx;
         vec_in.y = in_vec.y - dy;
         vec_in.z = in_vec.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= in_valid;
      vec_ff   <= vec_in;
      carry_ff <= in_carry;
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
   assign out_carry = carry_ff;

endmodule

### hw/rtl/amfp_mat.sv
// amfp_mat: four-stage quadrant fold, matrix terms and translation with rounding and clamp
// depends on amfp_pkg
module amfp_mat (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  amfp_pkg::cordic_type  in_vec,
   input  amfp_pkg::carry_type   in_carry,
   output logic                  out_valid,
   output amfp_pkg::rsp_type     out_word
);
   import amfp_pkg::*;

   logic [3:0]          valid_ff;
   logic [3:0]          valid_in;
   carry_type           c1_ff, c2_ff, c3_ff;
   logic signed [64:0]  pxx1_ff, pxy1_ff, pyx1_ff, pyy1_ff;
   logic signed [31:0]  xx2_ff, xy2_ff, yx2_ff, yy2_ff;
   logic signed [31:0]  xx3_ff, xy3_ff, yx3_ff, yy3_ff;
   logic signed [63:0]  qa3_ff, qb3_ff, qc3_ff, qd3_ff;
   rsp_type             rsp4_ff, rsp4_in;

   // stage 1: fold quadrant, form scale times trig products
   logic signed [32:0] cv, sv;
   always_comb begin
      case (in_carry.quad)
         2'd0: begin
            cv = 33'(in_vec.x);
            sv = 33'(in_vec.y);
         end
         2'd1: begin
            cv = -33'(in_vec.y);
            sv = 33'(in_vec.x);
         end
         2'd2: begin
            cv = -33'(in_vec.x);
            sv = -33'(in_vec.y);
         end
         default: begin
            cv = 33'(in_vec.y);
            sv = -33'(in_vec.x);
         end
      endcase
   end

   // stage 2: round away trig fraction bits and clamp
   function automatic logic signed [31:0] rnd_trig(input logic signed [64:0] p);
      logic signed [65:0] t;
      t = 66'(p) + (66'sd1 <<< (TRIG_FRAC - 1));
      return sat32(56'($signed(t[65:TRIG_FRAC])));
   endfunction

   // stage 4: round origin products to the output fraction
   function automatic logic signed [55:0] rnd_frac(input logic signed [63:0] p);
      logic signed [64:0] t;
      t = 65'(p) + (65'sd1 <<< (FRAC_BITS - 1));
      return 56'($signed(t[64:FRAC_BITS]));
   endfunction

   always_comb begin
      rsp4_in.xx_term       = xx3_ff;
      rsp4_in.xy_term       = xy3_ff;
      rsp4_in.yx_term       = yx3_ff;
      rsp4_in.yy_term       = yy3_ff;
      rsp4_in.shift_x       = sat32(56'(c3_ff.pos_x) - rnd_frac(qa3_ff) - rnd_frac(qb3_ff));
      rsp4_in.shift_y       = sat32(56'(c3_ff.pos_y) - rnd_frac(qc3_ff) - rnd_frac(qd3_ff));
      rsp4_in.angle_wrapped = c3_ff.angle_wrapped;
   end

   assign valid_in = {valid_ff[2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= '0;
      else
         valid_ff <= valid_in;
      // products
      c1_ff   <= in_carry;
      pxx1_ff <= 65'(in_carry.scale_x) * 65'(cv);
      pxy1_ff <= 65'(in_carry.scale_y) * (-65'(sv));
      pyx1_ff <= 65'(in_carry.scale_x) * 65'(sv);
      pyy1_ff <= 65'(in_carry.scale_y) * 65'(cv);
      // matrix terms
      c2_ff  <= c1_ff;
      xx2_ff <= rnd_trig(pxx1_ff);
      xy2_ff <= rnd_trig(pxy1_ff);
      yx2_ff <= rnd_trig(pyx1_ff);
      yy2_ff <= rnd_trig(pyy1_ff);
      // origin products
      c3_ff  <= c2_ff;
      xx3_ff <= xx2_ff;
      xy3_ff <= xy2_ff;
      yx3_ff <= yx2_ff;
      yy3_ff <= yy2_ff;
      qa3_ff <= 64'(c2_ff.origin_x) * 64'(xx2_ff);
      qb3_ff <= 64'(c2_ff.origin_y) * 64'(xy2_ff);
      qc3_ff <= 64'(c2_ff.origin_x) * 64'(yx2_ff);
      qd3_ff <= 64'(c2_ff.origin_y) * 64'(yy2_ff);
      // result
      rsp4_ff <= rsp4_in;
   end

   assign out_valid = valid_ff[3];
   assign out_word  = rsp4_ff;

endmodule

### hw/rtl/affine_matrix_from_pose_2d_core.sv
// affine_matrix_from_pose_2d_core: pose to 2D affine matrix terms, fully pipelined
// a word runs from start through amfp_wrap, the row of amfp_cell stages and amfp_mat to rsp_strobe
// throughput: one word per cycle; busy is always low, every stage is a register slice
// the result sits on rsp_word for one cycle with rsp_strobe; the receiver cannot stall
// reset clears only the valid bits; words in flight at reset are dropped
// depends on amfp_pkg, amfp_wrap, amfp_cell, amfp_mat
module affine_matrix_from_pose_2d_core #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  amfp_pkg::req_type  req_word,
   output logic               rsp_strobe,
   output amfp_pkg::rsp_type  rsp_word
);
   import amfp_pkg::*;

   logic       chain_valid [CORDIC_STEPS+1];
   cordic_type chain_vec   [CORDIC_STEPS+1];
   carry_type  chain_carry [CORDIC_STEPS+1];

   // never stalls
   assign busy = 1'b0;

   // angle reduction front end
   amfp_wrap u_wrap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_word   (req_word),
      .out_valid (chain_valid[0]),
      .out_carry (chain_carry[0]),
      .out_vec   (chain_vec[0])
   );

   // row of rotation cells
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      amfp_cell #(
         .STEP (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_vec    (chain_vec[i]),
         .in_carry  (chain_carry[i]),
         .out_valid (chain_valid[i+1]),
         .out_vec   (chain_vec[i+1]),
         .out_carry (chain_carry[i+1])
      );
   end

   // matrix terms and translation
   amfp_mat u_mat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[CORDIC_STEPS]),
      .in_vec    (chain_vec[CORDIC_STEPS]),
      .in_carry  (chain_carry[CORDIC_STEPS]),
      .out_valid (rsp_strobe),
      .out_word  (rsp_word)
   );

endmodule
